// File: design/rwhp_pkg.sv
package rwhp_pkg;

    // Width of the byte position counter; the position saturates at all ones.
    localparam int POSITION_BITS = 34;

    // Chunk arithmetic needs room for position + 8 + a 32-bit size + pad.
    localparam int SUM_W = ((POSITION_BITS + 1 > 32) ? POSITION_BITS + 1 : 32) + 1;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    localparam int CHUNK_FIRST  = 12;
    localparam int HDR_LEN      = 8;
    localparam int MIN_FILE_LEN = 44;
    localparam int FMT_MIN_SIZE = 16;

    localparam logic [31:0] ID_FMT  = 32'h666D_7420;
    localparam logic [31:0] ID_DATA = 32'h6461_7461;

    localparam logic [15:0] PCM_FORMAT   = 16'd1;
    localparam logic [15:0] PCM_BITS     = 16'd16;
    localparam logic [15:0] CHAN_DEFAULT = 16'd1;
    localparam logic [31:0] RATE_DEFAULT = 32'd44100;

    localparam int STATUS_W = 3;
    localparam int OUT_FIELDS_W = STATUS_W + 16 + 32 + 31 + 32;
    localparam int OUT_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_NOT_WAVE = 3'd2,
        ST_NO_DATA  = 3'd3,
        ST_NOT_PCM  = 3'd4,
        ST_NOT_16   = 3'd5
    } status_t;

    // Expected header bytes; only offsets 0..3 and 8..11 are checked.
    function automatic logic [7:0] tag_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h52;  // R
            4'd1:    b = 8'h49;  // I
            4'd2:    b = 8'h46;  // F
            4'd3:    b = 8'h46;  // F
            4'd8:    b = 8'h57;  // W
            4'd9:    b = 8'h41;  // A
            4'd10:   b = 8'h56;  // V
            4'd11:   b = 8'h45;  // E
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

// File: design/riff_wave_header_parser.sv
// The result is registered on m_axis in the cycle after the final byte (tlast) is accepted.
// One byte per cycle while s_axis_tready is high; all chunk tracking is done as it arrives.
// The output register frees the input side while a result waits, unless m_axis is stalled.
// Reset: synchronous, active low; parser state returns to its start values, also after
// every final byte, so files may follow each other with no gap.
module riff_wave_header_parser import rwhp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] data_byte
    input  logic             s_axis_tlast,   // last_byte
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [2:0] status, [18:3] channels, [50:19] sample_rate, [81:51] sample_count,
    // [113:82] data_offset, rest zero
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam logic [SUM_W-1:0] HDR_END_RESET = SUM_W'(CHUNK_FIRST + HDR_LEN - 1);

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [SUM_W-1:0]         hdr_end_reg, hdr_end_next;   // chunk start + 7
    logic [63:0]              hdr_reg, hdr_next;
    logic                     tag_ok_reg, tag_ok_next;
    logic                     fmt_act_reg, fmt_act_next;
    logic [SUM_W-1:0]         fmt_end_reg, fmt_end_next;
    logic [4:0]               fmt_idx_reg, fmt_idx_next;
    logic [15:0]              fmtp_code_reg, fmtp_code_next;
    logic [15:0]              fmtp_chan_reg, fmtp_chan_next;
    logic [31:0]              fmtp_rate_reg, fmtp_rate_next;
    logic [15:0]              fmtp_bits_reg, fmtp_bits_next;
    logic [15:0]              format_reg, format_next;
    logic [15:0]              chan_reg, chan_next;
    logic [31:0]              rate_reg, rate_next;
    logic [15:0]              bits_reg, bits_next;
    logic                     data_found_reg, data_found_next;
    logic [31:0]              data_bytes_reg, data_bytes_next;
    logic [31:0]              data_start_reg, data_start_next;

    logic                     out_valid_reg;
    logic [OUT_W-1:0]         out_data_reg;

    logic                     accept;
    logic                     parse;
    logic [7:0]               byte_in;
    logic [SUM_W-1:0]         pos_ext;
    logic [31:0]              size;
    logic [SUM_W-1:0]         payload;
    logic [SUM_W-1:0]         chunk_end;
    logic [SUM_W-1:0]         chunk_sat;
    status_t                  status;
    logic [OUT_W-1:0]         result;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign parse         = accept && (pos_reg != POS_MAX);
    assign byte_in       = s_axis_tdata[7:0];
    assign pos_ext       = SUM_W'(pos_reg);

    assign hdr_next  = {hdr_reg[55:0], byte_in};
    assign size      = swap32(hdr_next[31:0]);
    assign payload   = hdr_end_reg + SUM_W'(1);
    assign chunk_end = payload + SUM_W'(size) + SUM_W'(size[0]);
    assign chunk_sat = (chunk_end > SUM_W'(POS_MAX)) ? SUM_W'(POS_MAX) : chunk_end;

    always_comb begin
        pos_next        = pos_reg;
        hdr_end_next    = hdr_end_reg;
        tag_ok_next     = tag_ok_reg;
        fmt_act_next    = fmt_act_reg;
        fmt_end_next    = fmt_end_reg;
        fmt_idx_next    = fmt_idx_reg;
        fmtp_code_next  = fmtp_code_reg;
        fmtp_chan_next  = fmtp_chan_reg;
        fmtp_rate_next  = fmtp_rate_reg;
        fmtp_bits_next  = fmtp_bits_reg;
        format_next     = format_reg;
        chan_next       = chan_reg;
        rate_next       = rate_reg;
        bits_next       = bits_reg;
        data_found_next = data_found_reg;
        data_bytes_next = data_bytes_reg;
        data_start_next = data_start_reg;

        if (parse) begin
            if (pos_reg < POSITION_BITS'(CHUNK_FIRST) &&
                (pos_reg < POSITION_BITS'(4) || pos_reg >= POSITION_BITS'(8)) &&
                byte_in != tag_byte(pos_reg[3:0])) begin
                tag_ok_next = 1'b0;
            end

            // fmt payload: code, channels, rate in bytes 0..7, bits in 14..15
            if (fmt_act_reg && !fmt_idx_reg[4]) begin
                case (fmt_idx_reg[3:0])
                    4'd0:    fmtp_code_next[7:0]    = byte_in;
                    4'd1:    fmtp_code_next[15:8]   = byte_in;
                    4'd2:    fmtp_chan_next[7:0]    = byte_in;
                    4'd3:    fmtp_chan_next[15:8]   = byte_in;
                    4'd4:    fmtp_rate_next[7:0]    = byte_in;
                    4'd5:    fmtp_rate_next[15:8]   = byte_in;
                    4'd6:    fmtp_rate_next[23:16]  = byte_in;
                    4'd7:    fmtp_rate_next[31:24]  = byte_in;
                    4'd14:   fmtp_bits_next[7:0]    = byte_in;
                    4'd15:   fmtp_bits_next[15:8]   = byte_in;
                    default: ;
                endcase
                fmt_idx_next = fmt_idx_reg + 5'd1;
            end

            // fmt chunk complete inside the file: commit its values
            if (fmt_act_reg && pos_ext == fmt_end_reg) begin
                format_next  = fmtp_code_next;
                chan_next    = fmtp_chan_next;
                rate_next    = fmtp_rate_next;
                bits_next    = fmtp_bits_next;
                fmt_act_next = 1'b0;
            end

            if (pos_ext == hdr_end_reg) begin
                if (hdr_next[63:32] == ID_FMT) begin
                    if (size >= 32'(FMT_MIN_SIZE)) begin
                        fmt_act_next   = 1'b1;
                        fmt_end_next   = payload + SUM_W'(size) - SUM_W'(1);
                        fmt_idx_next   = '0;
                        fmtp_code_next = '0;
                        fmtp_chan_next = '0;
                        fmtp_rate_next = '0;
                        fmtp_bits_next = '0;
                    end
                end else if (hdr_next[63:32] == ID_DATA) begin
                    data_found_next = 1'b1;
                    data_bytes_next = size;
                    data_start_next = payload[31:0];
                end
                hdr_end_next = chunk_sat + SUM_W'(HDR_LEN - 1);
            end

            pos_next = pos_reg + POSITION_BITS'(1);
        end
    end

    // File length is pos + 1, or the saturated position itself
    always_comb begin
        if (pos_reg < POSITION_BITS'(MIN_FILE_LEN - 1)) begin
            status = ST_SHORT;
        end else if (!tag_ok_reg) begin
            status = ST_NOT_WAVE;
        end else if (!data_found_next || data_bytes_next == 32'd0) begin
            status = ST_NO_DATA;
        end else if (format_next != PCM_FORMAT) begin
            status = ST_NOT_PCM;
        end else if (bits_next != PCM_BITS) begin
            status = ST_NOT_16;
        end else begin
            status = ST_OK;
        end

        if (status == ST_OK) begin
            result = OUT_W'({data_start_next, data_bytes_next[31:1], rate_next, chan_next,
                             status});
        end else begin
            result = OUT_W'({32'd0, 31'd0, RATE_DEFAULT, CHAN_DEFAULT, status});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_axis_tlast)) begin
            pos_reg        <= '0;
            hdr_end_reg    <= HDR_END_RESET;
            hdr_reg        <= '0;
            tag_ok_reg     <= 1'b1;
            fmt_act_reg    <= 1'b0;
            fmt_end_reg    <= '0;
            fmt_idx_reg    <= '0;
            fmtp_code_reg  <= '0;
            fmtp_chan_reg  <= '0;
            fmtp_rate_reg  <= '0;
            fmtp_bits_reg  <= '0;
            format_reg     <= '0;
            chan_reg       <= CHAN_DEFAULT;
            rate_reg       <= RATE_DEFAULT;
            bits_reg       <= PCM_BITS;
            data_found_reg <= 1'b0;
            data_bytes_reg <= '0;
            data_start_reg <= '0;
        end else begin
            pos_reg        <= pos_next;
            hdr_end_reg    <= hdr_end_next;
            if (parse) begin
                hdr_reg    <= hdr_next;
            end
            tag_ok_reg     <= tag_ok_next;
            fmt_act_reg    <= fmt_act_next;
            fmt_end_reg    <= fmt_end_next;
            fmt_idx_reg    <= fmt_idx_next;
            fmtp_code_reg  <= fmtp_code_next;
            fmtp_chan_reg  <= fmtp_chan_next;
            fmtp_rate_reg  <= fmtp_rate_next;
            fmtp_bits_reg  <= fmtp_bits_next;
            format_reg     <= format_next;
            chan_reg       <= chan_next;
            rate_reg       <= rate_next;
            bits_reg       <= bits_next;
            data_found_reg <= data_found_next;
            data_bytes_reg <= data_bytes_next;
            data_start_reg <= data_start_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept && s_axis_tlast) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_axis_tlast) begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// File: design/rwhp_checker.sv
module rwhp_checker import rwhp_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [7:0]       s_axis_tdata,
    input logic             s_axis_tlast,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // Stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // Input backpressure comes only from a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output register");

    // Final byte of a file yields a result on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
        else $error("no result after final byte");

    // Failing files report defaults and a known code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[2:0] != ST_OK |->
            m_axis_tdata[OUT_W-1:51] == '0 && m_axis_tdata[50:19] == RATE_DEFAULT &&
            m_axis_tdata[18:3] == CHAN_DEFAULT && m_axis_tdata[2:0] <= ST_NOT_16)
        else $error("bad result word on failed file");

endmodule

bind riff_wave_header_parser rwhp_checker u_rwhp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
